FILE: rtl/core/pap_pkg.sv
// ============================================================================
// pap_pkg
// Shared types and codes for the precipitation array packet parser.
// ============================================================================
package pap_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_RECORD  = 2'd0;
    localparam logic [1:0] STATUS_BAD_CODE = 2'd1;
    localparam logic [1:0] STATUS_BAD_ROWS = 2'd2;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd3;

    // Configuration register indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_EXPECTED_CODE = 2'd0;
    localparam logic [1:0] REG_EXPECTED_ROWS = 2'd1;
    localparam logic [1:0] REG_MAX_ROW_BYTES = 2'd2;

    // Register reset values.
    localparam logic [15:0] EXPECTED_CODE_RESET = 16'd17;
    localparam logic [9:0]  EXPECTED_ROWS_RESET = 10'd131;
    localparam logic [9:0]  MAX_ROW_BYTES_RESET = 10'd262;

    // Position of the last header byte, and of the second code byte.
    localparam logic [3:0] HEADER_LAST_POS = 4'd9;
    localparam logic [3:0] HEADER_CODE_POS = 4'd1;

    // Smallest legal row byte count.
    localparam logic [15:0] MIN_ROW_BYTES = 16'd2;

    typedef struct packed {
        logic [15:0] expected_code;
        logic [9:0]  expected_rows;
        logic [9:0]  max_row_bytes;
    } cfg_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] row_number;
        logic [7:0] run_length;
        logic [7:0] level_value;
        logic       last_in_row;
        logic       last_in_packet;
    } result_t;

endpackage

FILE: rtl/core/pap_regs.sv
// ============================================================================
// pap_regs
// APB-style configuration registers of the packet parser.
// ============================================================================
module pap_regs
    import pap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_code <= EXPECTED_CODE_RESET;
            cfg_reg.expected_rows <= EXPECTED_ROWS_RESET;
            cfg_reg.max_row_bytes <= MAX_ROW_BYTES_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_EXPECTED_CODE: cfg_reg.expected_code <= pwdata[15:0];
                REG_EXPECTED_ROWS: cfg_reg.expected_rows <= pwdata[9:0];
                REG_MAX_ROW_BYTES: cfg_reg.max_row_bytes <= pwdata[9:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_EXPECTED_CODE: prdata = {16'd0, cfg_reg.expected_code};
            REG_EXPECTED_ROWS: prdata = {22'd0, cfg_reg.expected_rows};
            REG_MAX_ROW_BYTES: prdata = {22'd0, cfg_reg.max_row_bytes};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/core/pap_parser.sv
// ============================================================================
// pap_parser
// Parser state and the per-byte next-state and result logic.
// ============================================================================
module pap_parser
    import pap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       start_of_packet,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_ROWLEN = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    logic [2:0] phase_reg, phase_next;
    logic [3:0] hpos_reg, hpos_next;
    logic [7:0] high_reg, high_next;
    logic       mism_reg, mism_next;
    logic [9:0] row_reg, row_next;
    logic [8:0] pairs_reg, pairs_next;
    logic [7:0] run_reg, run_next;

    // Values after a start flag has been applied.
    logic [2:0]  ph;
    logic [3:0]  hpos;
    logic        mism;
    logic [9:0]  row;
    logic [8:0]  pairs;
    logic [15:0] word;
    logic [10:0] row_plus;
    logic        lr;
    logic        lp;

    assign ph       = start_of_packet ? PH_HEADER : phase_reg;
    assign hpos     = start_of_packet ? 4'd0 : hpos_reg;
    assign mism     = start_of_packet ? 1'b0 : mism_reg;
    assign row      = start_of_packet ? 10'd0 : row_reg;
    assign pairs    = start_of_packet ? 9'd0 : pairs_reg;
    assign word     = {high_reg, data_byte};
    assign row_plus = {1'b0, row} + 11'd1;
    assign lr       = (pairs <= 9'd1);
    assign lp       = lr && (row_plus >= {1'b0, cfg.expected_rows});

    always_comb
    begin
        phase_next = ph;
        hpos_next  = hpos;
        high_next  = high_reg;
        mism_next  = mism;
        row_next   = row;
        pairs_next = pairs;
        run_next   = run_reg;
        res_valid  = 1'b0;
        res        = '0;

        unique case (ph)
            PH_HEADER:
            begin
                if (hpos == HEADER_CODE_POS)
                begin
                    mism_next = (word != cfg.expected_code);
                end
                if (hpos == HEADER_LAST_POS)
                begin
                    hpos_next = 4'd0;
                    if (mism_next)
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.status = STATUS_BAD_CODE;
                    end
                    else if (word != {6'd0, cfg.expected_rows})
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.status = STATUS_BAD_ROWS;
                    end
                    else
                    begin
                        row_next   = 10'd0;
                        phase_next = (cfg.expected_rows == 10'd0) ? PH_DONE : PH_ROWLEN;
                    end
                end
                else
                begin
                    high_next = data_byte;
                    hpos_next = hpos + 4'd1;
                end
            end
            PH_ROWLEN:
            begin
                if (hpos == 4'd0)
                begin
                    high_next = data_byte;
                    hpos_next = 4'd1;
                end
                else
                begin
                    hpos_next = 4'd0;
                    if (word < MIN_ROW_BYTES || word > {6'd0, cfg.max_row_bytes} || word[0])
                    begin
                        phase_next     = PH_ERROR;
                        res_valid      = 1'b1;
                        res.status     = STATUS_BAD_LEN;
                        res.row_number = row;
                    end
                    else
                    begin
                        pairs_next = word[9:1];
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (hpos == 4'd0)
                begin
                    run_next  = data_byte;
                    hpos_next = 4'd1;
                end
                else
                begin
                    hpos_next          = 4'd0;
                    res_valid          = 1'b1;
                    res.status         = STATUS_RECORD;
                    res.row_number     = row;
                    res.run_length     = run_reg;
                    res.level_value    = data_byte;
                    res.last_in_row    = lr;
                    res.last_in_packet = lp;
                    pairs_next         = pairs - 9'd1;
                    if (lr)
                    begin
                        pairs_next = 9'd0;
                        if (lp)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            row_next   = row_plus[9:0];
                            phase_next = PH_ROWLEN;
                        end
                    end
                end
            end
            default:
            begin
                // Idle, done and error phases ignore bytes until a start flag.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hpos_reg  <= 4'd0;
            high_reg  <= 8'd0;
            mism_reg  <= 1'b0;
            row_reg   <= 10'd0;
            pairs_reg <= 9'd0;
            run_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            high_reg  <= high_next;
            mism_reg  <= mism_next;
            row_reg   <= row_next;
            pairs_reg <= pairs_next;
            run_reg   <= run_next;
        end
    end

endmodule

FILE: rtl/core/precip_array_packet_parser_top.sv
// ============================================================================
// precip_array_packet_parser_top
// Byte-serial parser for a digital precipitation array packet.
// ============================================================================
//
//  Channel   Handshake                  Word contents
//  -------   -------------------------  ------------------------------------
//  input     in_valid / in_stall        data_byte, start_of_packet
//  output    out_valid / out_stall      status, row_number, run_length,
//                                       level_value, last_in_row,
//                                       last_in_packet
//  config    psel/penable/pwrite/pready expected_code, expected_rows,
//                                       max_row_bytes at 0x0, 0x4, 0x8
//
// The block takes one input word per cycle while in_stall is low, and produces
// at most one output word per input word; a taken word goes into the input
// register, and its result, if any, is written into the result register when
// the parser steps on that word.
// The parser step between the input register and the result register is
// combinational.
// Reset clears the parser to idle and the registers to their defaults.
// A stalled output holds the result register; the input register then stalls
// the input side only when it holds a word that cannot move forward.
//
module precip_array_packet_parser_top
    import pap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_of_packet,
    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [9:0]  row_number,
    output logic [7:0]  run_length,
    output logic [7:0]  level_value,
    output logic        last_in_row,
    output logic        last_in_packet
);

    cfg_t    cfg;
    result_t res;
    logic    res_valid;

    // Input register.
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_sop_reg;

    // Result register.
    logic    out_vld_reg;
    result_t out_reg;

    logic advance;
    logic in_accept;

    // The input register moves on when the result register is empty or is
    // being emptied this cycle; words that yield no result follow the same
    // rule.
    assign advance   = !out_vld_reg || !out_stall;
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    pap_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pap_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .step            (in_vld_reg && advance),
        .data_byte       (in_byte_reg),
        .start_of_packet (in_sop_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
            in_sop_reg  <= start_of_packet;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_vld_reg && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_vld_reg;
    assign status         = out_reg.status;
    assign row_number     = out_reg.row_number;
    assign run_length     = out_reg.run_length;
    assign level_value    = out_reg.level_value;
    assign last_in_row    = out_reg.last_in_row;
    assign last_in_packet = out_reg.last_in_packet;

endmodule

FILE: tb/sv/precip_array_packet_parser_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// precip_array_packet_parser_top_tb
// Self-checking bench for the byte-serial precipitation array packet parser.
// Packets go in one byte word at a time, and a model of the parser state
// predicts every record and error word. Both channels idle and stall at random.
// ============================================================================
module precip_array_packet_parser_top_tb;
    import pap_pkg::*;

    // One byte word of the input stream.
    typedef struct packed {
        logic [7:0] data;
        logic       sop;
    } stream_word_t;

    // Parser phases of the prediction model.
    typedef enum logic [2:0] {
        PS_IDLE,
        PS_HEADER,
        PS_ROW_LEN,
        PS_PAIRS,
        PS_DONE,
        PS_DROP
    } parse_phase_t;

    // Clock, reset and every block input start at known values.
    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid        = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte       = '0;
    logic        start_of_packet = 1'b0;
    logic        out_valid;
    logic        out_stall       = 1'b0;
    logic [1:0]  status;
    logic [9:0]  row_number;
    logic [7:0]  run_length;
    logic [7:0]  level_value;
    logic        last_in_row;
    logic        last_in_packet;

    precip_array_packet_parser_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .start_of_packet (start_of_packet),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .row_number      (row_number),
        .run_length      (run_length),
        .level_value     (level_value),
        .last_in_row     (last_in_row),
        .last_in_packet  (last_in_packet)
    );

    // 10 ns clock period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Queues, counters and the mirrored register and parser state.
    // ------------------------------------------------------------------------

    // Byte words waiting for the driver, and the packet under construction.
    stream_word_t pending_bytes[$];
    stream_word_t staged_bytes[$];

    // Records and error words predicted but not yet seen on the output.
    result_t      expected_results[$];

    int           mismatch_count = 0;

    // Idle and stall pacing. A calm counter, while nonzero, forces zero waits
    // so that long back-to-back stretches occur on both channels.
    int           send_wait  = 0;
    int           send_calm  = 0;
    int           hold_left  = 0;
    int           hold_calm  = 0;
    logic         in_taken   = 1'b0;

    // Mirror of the configuration registers.
    logic [15:0]  cfg_code      = EXPECTED_CODE_RESET;
    logic [9:0]   cfg_rows      = EXPECTED_ROWS_RESET;
    logic [9:0]   cfg_max_bytes = MAX_ROW_BYTES_RESET;

    // Mirror of the parser state.
    parse_phase_t ps_phase    = PS_IDLE;
    logic [3:0]   ps_pos      = '0;
    logic [7:0]   ps_high     = '0;
    logic         ps_code_bad = 1'b0;
    logic [9:0]   ps_row      = '0;
    logic [8:0]   ps_pairs    = '0;
    logic [7:0]   ps_run      = '0;

    // ------------------------------------------------------------------------
    // Prediction: advance the mirrored parser by one byte. Returns 1 and
    // fills rec when the byte produces an output word.
    // ------------------------------------------------------------------------
    function automatic bit parse_byte(input logic [7:0] b, input logic sop,
                                      output result_t rec);
        logic [15:0] pair_word;
        logic        end_row;
        logic        end_pkt;
        rec = '0;
        // A start flag restarts the parser; that byte is header byte zero.
        if (sop)
        begin
            ps_phase    = PS_HEADER;
            ps_pos      = '0;
            ps_code_bad = 1'b0;
            ps_row      = '0;
            ps_pairs    = '0;
        end
        pair_word = {ps_high, b};
        case (ps_phase)
            PS_HEADER:
            begin
                if (ps_pos == HEADER_CODE_POS)
                    ps_code_bad = (pair_word != cfg_code);
                if (ps_pos == HEADER_LAST_POS)
                begin
                    ps_pos = '0;
                    // A bad code wins over a bad row count.
                    if (ps_code_bad)
                    begin
                        ps_phase   = PS_DROP;
                        rec.status = STATUS_BAD_CODE;
                        return 1'b1;
                    end
                    if (pair_word != {6'd0, cfg_rows})
                    begin
                        ps_phase   = PS_DROP;
                        rec.status = STATUS_BAD_ROWS;
                        return 1'b1;
                    end
                    // A header with zero rows ends the packet at once.
                    ps_row   = '0;
                    ps_phase = (cfg_rows == 10'd0) ? PS_DONE : PS_ROW_LEN;
                    return 1'b0;
                end
                ps_high = b;
                ps_pos  = ps_pos + 4'd1;
                return 1'b0;
            end
            PS_ROW_LEN:
            begin
                if (ps_pos == 4'd0)
                begin
                    ps_high = b;
                    ps_pos  = 4'd1;
                    return 1'b0;
                end
                ps_pos = '0;
                if (pair_word < MIN_ROW_BYTES || pair_word > {6'd0, cfg_max_bytes}
                    || pair_word[0])
                begin
                    ps_phase       = PS_DROP;
                    rec.status     = STATUS_BAD_LEN;
                    rec.row_number = ps_row;
                    return 1'b1;
                end
                ps_pairs = pair_word[9:1];
                ps_phase = PS_PAIRS;
                return 1'b0;
            end
            PS_PAIRS:
            begin
                if (ps_pos == 4'd0)
                begin
                    ps_run = b;
                    ps_pos = 4'd1;
                    return 1'b0;
                end
                ps_pos  = '0;
                end_row = (ps_pairs <= 9'd1);
                // The row limit is read live, so a register change mid-packet
                // can end the packet early.
                end_pkt = end_row && ({1'b0, ps_row} + 11'd1 >= {1'b0, cfg_rows});
                rec.status         = STATUS_RECORD;
                rec.row_number     = ps_row;
                rec.run_length     = ps_run;
                rec.level_value    = b;
                rec.last_in_row    = end_row;
                rec.last_in_packet = end_pkt;
                ps_pairs = ps_pairs - 9'd1;
                if (end_row)
                begin
                    ps_pairs = '0;
                    if (end_pkt)
                        ps_phase = PS_DONE;
                    else
                    begin
                        ps_row   = ps_row + 10'd1;
                        ps_phase = PS_ROW_LEN;
                    end
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and pacing helpers.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [9:0] got,
                               input logic [9:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Wait before the next word: a random draw, or none during a calm stretch.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 19);
    endfunction

    // Random byte that favors the extremes now and then.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input driver. Words change only at the falling edge; a word that was
    // taken at the last rising edge is replaced or withdrawn, a stalled word
    // is held. in_valid gets exactly one assignment per edge.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : byte_driver
        logic         next_valid;
        stream_word_t cur;
        next_valid = in_valid;
        if (in_valid && in_taken)
            next_valid = 1'b0;
        if (!next_valid && rst_n)
        begin
            if (send_wait > 0)
                send_wait--;
            else if (pending_bytes.size() > 0)
            begin
                cur = pending_bytes.pop_front();
                data_byte       <= cur.data;
                start_of_packet <= cur.sop;
                next_valid = 1'b1;
                send_wait  = draw_wait(send_calm);
            end
        end
        in_valid <= next_valid;
    end

    // Every accepted byte word runs through the prediction model at once.
    always @(posedge clk)
    begin : byte_predictor
        result_t rec;
        if (rst_n && in_valid && !in_stall)
        begin
            if (parse_byte(data_byte, start_of_packet, rec))
                expected_results.push_back(rec);
            in_taken <= 1'b1;
        end
        else
            in_taken <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Output side. The stall is held for a drawn number of cycles while a word
    // is offered, and toggles at random while nothing is offered.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : stall_driver
        if (out_valid === 1'b1 && hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (out_valid !== 1'b1)
            out_stall <= ($urandom_range(0, 7) == 0);
        else
            out_stall <= 1'b0;
    end

    // Each accepted output word is checked against the oldest prediction.
    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected word: status %0d row %0d",
                                          status, row_number));
            else
            begin
                want = expected_results.pop_front();
                check_field("status",         10'(status),         10'(want.status));
                check_field("row_number",     row_number,          want.row_number);
                check_field("run_length",     10'(run_length),     10'(want.run_length));
                check_field("level_value",    10'(level_value),    10'(want.level_value));
                check_field("last_in_row",    10'(last_in_row),    10'(want.last_in_row));
                check_field("last_in_packet", 10'(last_in_packet), 10'(want.last_in_packet));
            end
            hold_left = draw_wait(hold_calm);
        end
    end

    // ------------------------------------------------------------------------
    // Configuration access: an APB write followed by a read-back. Only called
    // while the parser pipeline is empty.
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        if (idx == REG_EXPECTED_CODE)
            stored = {16'd0, value[15:0]};
        else
            stored = {22'd0, value[9:0]};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        // Setup of the read-back follows the write access directly.
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== stored)
            report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                      idx, prdata, stored));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_EXPECTED_CODE: cfg_code      = stored[15:0];
            REG_EXPECTED_ROWS: cfg_rows      = stored[9:0];
            REG_MAX_ROW_BYTES: cfg_max_bytes = stored[9:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [15:0] code, input logic [9:0] rows,
                                  input logic [9:0] max_bytes);
        // Upper bits carry junk the block must drop.
        write_reg(REG_EXPECTED_CODE, {16'($urandom), code});
        write_reg(REG_EXPECTED_ROWS, {22'($urandom), rows});
        write_reg(REG_MAX_ROW_BYTES, {22'($urandom), max_bytes});
    endtask

    // Wait until every word is sent and every prediction has been met, then
    // give words that produce no output time to leave the pipeline.
    task automatic settle();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Packet construction. Bytes are staged first so that a packet can be cut
    // short before it is handed to the driver.
    // ------------------------------------------------------------------------
    function automatic void stage_byte(input logic [7:0] b, input logic sop);
        stream_word_t w;
        w.data = b;
        w.sop  = sop;
        staged_bytes.push_back(w);
    endfunction

    // Header: code, six bytes that the parser skips, row count.
    function automatic void stage_header(input logic [15:0] code, input logic [15:0] rows);
        stage_byte(code[15:8], 1'b1);
        stage_byte(code[7:0], 1'b0);
        repeat (6) stage_byte(rand_byte(), 1'b0);
        stage_byte(rows[15:8], 1'b0);
        stage_byte(rows[7:0], 1'b0);
    endfunction

    function automatic void stage_row(input logic [15:0] len, input int pairs);
        stage_byte(len[15:8], 1'b0);
        stage_byte(len[7:0], 1'b0);
        repeat (2 * pairs) stage_byte(rand_byte(), 1'b0);
    endfunction

    // Hands the first keep staged bytes to the driver and drops the staging.
    function automatic int send_staged(input int keep);
        for (int i = 0; i < keep; i++)
            pending_bytes.push_back(staged_bytes[i]);
        staged_bytes.delete();
        return keep;
    endfunction

    // One random packet under the current register values. Most packets are
    // well formed; the rest carry a bad code, a bad row count, a bad row
    // length, or are cut short by the next start flag. Returns the number of
    // bytes that count toward the stimulus budget.
    function automatic int random_packet();
        int          kind;
        int          bad_row;
        int          pairs;
        int          pair_cap;
        int          sent;
        logic [15:0] len;
        kind     = $urandom_range(0, 9);
        bad_row  = (kind == 8) ? $urandom_range(0, cfg_rows - 1) : -1;
        pair_cap = (cfg_max_bytes / 2 > 5) ? 5 : cfg_max_bytes / 2;
        case (kind)
            6: stage_header(cfg_code ^ 16'($urandom_range(1, 65535)),
                            $urandom_range(0, 1) ? {6'd0, cfg_rows} : 16'($urandom));
            7: stage_header(cfg_code, {6'd0, cfg_rows} ^ 16'($urandom_range(1, 65535)));
            default: stage_header(cfg_code, {6'd0, cfg_rows});
        endcase
        if (kind != 6 && kind != 7)
        begin
            for (int r = 0; r < cfg_rows; r++)
            begin
                if (r == bad_row)
                begin
                    // Every choice below breaks the length rule.
                    case ($urandom_range(0, 3))
                        0:       len = 16'($urandom_range(0, 1));
                        1:       len = 16'(cfg_max_bytes | 10'd1);
                        2:       len = 16'(cfg_max_bytes) + 16'($urandom_range(1, 4));
                        default: len = 16'($urandom) | 16'h0400;
                    endcase
                    stage_row(len, 0);
                    break;
                end
                pairs = $urandom_range(1, pair_cap);
                stage_row(16'(2 * pairs), pairs);
            end
        end
        if (kind == 9)
            sent = send_staged($urandom_range(1, staged_bytes.size() - 1));
        else
            sent = send_staged(staged_bytes.size());
        // Occasional stray bytes without a start flag; not counted.
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 3)) stage_byte(rand_byte(), 1'b0);
            void'(send_staged(staged_bytes.size()));
        end
        return sent;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          total;
        int          phase_items;
        logic [15:0] code;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values. Stray bytes while idle are ignored; a header with both
        // fields wrong reports only the bad code; then a bad row count alone.
        // A header interrupted by a new start flag restarts cleanly.
        stage_byte(8'hFF, 1'b0);
        stage_byte(8'h00, 1'b0);
        stage_header(16'hFFFF, 16'd0);
        stage_header(EXPECTED_CODE_RESET, 16'd130);
        stage_header(EXPECTED_CODE_RESET, 16'd131);
        void'(send_staged(staged_bytes.size() - 5));
        stage_header(16'd0, 16'd131);
        void'(send_staged(staged_bytes.size()));
        settle();

        // Smallest row limit and two rows: records with both end marks, then
        // rows of length four and zero rejected.
        write_all_regs(16'h0000, 10'd2, 10'd2);
        stage_header(16'h0000, 16'd2);
        stage_row(16'd2, 1);
        stage_row(16'd2, 1);
        stage_byte(8'hA5, 1'b0);
        stage_header(16'h0000, 16'd2);
        stage_row(16'd4, 0);
        stage_header(16'h0000, 16'd2);
        stage_row(16'd0, 0);
        void'(send_staged(staged_bytes.size()));
        settle();

        // Largest values: the longest legal row is accepted, a row count with
        // upper header bits set is rejected, and odd, oversized and one-byte
        // lengths are rejected.
        write_all_regs(16'hFFFF, 10'd1023, 10'd1022);
        stage_header(16'hFFFF, 16'd1023);
        stage_row(16'd1022, 2);
        stage_header(16'hFFFF, 16'h07FF);
        stage_header(16'hFFFF, 16'd1023);
        stage_row(16'd1023, 0);
        stage_header(16'hFFFF, 16'd1023);
        stage_row(16'd1024, 0);
        stage_header(16'hFFFF, 16'd1023);
        stage_row(16'd1, 0);
        void'(send_staged(staged_bytes.size()));
        settle();

        // Zero rows: a matching header ends the packet with no record.
        write_reg(REG_EXPECTED_ROWS, 32'd0);
        stage_header(16'hFFFF, 16'd0);
        stage_byte(8'h12, 1'b0);
        stage_byte(8'h34, 1'b0);
        stage_header(16'h1234, 16'd0);
        void'(send_staged(staged_bytes.size()));
        settle();

        // Row limit lowered in the middle of a packet: the row in progress
        // becomes the last one.
        write_all_regs(16'h0011, 10'd3, 10'd6);
        stage_header(16'h0011, 16'd3);
        stage_row(16'd4, 2);
        stage_row(16'd2, 0);
        void'(send_staged(staged_bytes.size()));
        settle();
        write_reg(REG_EXPECTED_ROWS, 32'd1);
        stage_byte(rand_byte(), 1'b0);
        stage_byte(rand_byte(), 1'b0);
        stage_byte(rand_byte(), 1'b0);
        void'(send_staged(staged_bytes.size()));
        settle();

        // Random part: several register settings, each with a run of packets.
        // The directed part above already sends close to 200 bytes.
        total = 0;
        while (total < 270)
        begin
            settle();
            case ($urandom_range(0, 3))
                0:       code = 16'h0000;
                1:       code = 16'hFFFF;
                default: code = 16'($urandom);
            endcase
            write_all_regs(code, 10'($urandom_range(1, 4)), 10'($urandom_range(2, 12)));
            phase_items = 0;
            while (phase_items < 75 && total + phase_items < 270)
                phase_items += random_packet();
            total += phase_items;
        end
        settle();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
